/* sv/tpre_pkg.sv */
// ----------------------------------------------------------------------------
// tpre_pkg
// Shared widths, types and sizes for the token position record encoder.
// ----------------------------------------------------------------------------
package tpre_pkg;

  localparam int CODE_W    = 16;
  localparam int POS_W     = 22;
  localparam int BYTE_W    = 8;
  localparam int MAX_BYTES = 11;
  localparam int BUF_W     = MAX_BYTES * BYTE_W;
  localparam int CNT_W     = 4;

  typedef logic [CODE_W-1:0] code_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // One input record.
  typedef struct packed {
    code_t token_code;
    pos_t  file_index;
    pos_t  line_number;
    pos_t  column_number;
  } record_t;

  // Serialized record: first byte in the low bits, count of valid bytes.
  typedef struct packed {
    logic [BUF_W-1:0] bytes;
    cnt_t             count;
  } packed_rec_t;

endpackage

/* sv/tpre_in_if.sv */
// ----------------------------------------------------------------------------
// tpre_in_if
// Record channel: valid/ready handshake with one token record per beat.
// ----------------------------------------------------------------------------
interface tpre_in_if;
  logic           valid;
  logic           ready;
  tpre_pkg::code_t token_code;
  tpre_pkg::pos_t  file_index;
  tpre_pkg::pos_t  line_number;
  tpre_pkg::pos_t  column_number;

  modport source (
    output valid, token_code, file_index, line_number, column_number,
    input  ready
  );
  modport sink (
    input  valid, token_code, file_index, line_number, column_number,
    output ready
  );
endinterface

/* sv/tpre_out_if.sv */
// ----------------------------------------------------------------------------
// tpre_out_if
// Byte channel: valid/ready handshake with one serialized byte per beat.
// ----------------------------------------------------------------------------
interface tpre_out_if;
  logic           valid;
  logic           ready;
  tpre_pkg::byte_t out_byte;
  logic           last_byte;

  modport source (
    output valid, out_byte, last_byte,
    input  ready
  );
  modport sink (
    input  valid, out_byte, last_byte,
    output ready
  );
endinterface

/* sv/tpre_pack.sv */
// ----------------------------------------------------------------------------
// tpre_pack
// Builds the full byte image of one record: two code bytes, then the three
// position values as varints (7-bit groups, 8-bit third byte), packed back to back.
// ----------------------------------------------------------------------------
module tpre_pack (
  input  tpre_pkg::record_t     rec,
  output tpre_pkg::packed_rec_t pck
);

  typedef struct packed {
    logic [23:0] bytes;
    logic [1:0]  len;
  } varint_t;

  function automatic varint_t encode_pos(input tpre_pkg::pos_t v);
    varint_t r;
    if (v[21:7] == 15'd0) begin
      r.bytes = {17'd0, v[6:0]};
      r.len   = 2'd1;
    end else if (v[21:14] == 8'd0) begin
      r.bytes = {9'd0, v[13:7], 1'b1, v[6:0]};
      r.len   = 2'd2;
    end else begin
      r.bytes = {v[21:14], 1'b1, v[13:7], 1'b1, v[6:0]};
      r.len   = 2'd3;
    end
    return r;
  endfunction

  varint_t    file_v;
  varint_t    line_v;
  varint_t    col_v;
  logic [6:0] line_off;
  logic [6:0] col_off;

  always_comb begin
    file_v = encode_pos(rec.file_index);
    line_v = encode_pos(rec.line_number);
    col_v  = encode_pos(rec.column_number);

    // Bit offsets of the line and column fields inside the byte image.
    line_off = 7'd16 + {2'b00, file_v.len, 3'b000};
    col_off  = line_off + {2'b00, line_v.len, 3'b000};

    pck.bytes = {{(tpre_pkg::BUF_W - 16){1'b0}}, rec.token_code}
              | ({{(tpre_pkg::BUF_W - 24){1'b0}}, file_v.bytes} << 16)
              | ({{(tpre_pkg::BUF_W - 24){1'b0}}, line_v.bytes} << line_off)
              | ({{(tpre_pkg::BUF_W - 24){1'b0}}, col_v.bytes} << col_off);
    pck.count = 4'd2 + {2'b00, file_v.len} + {2'b00, line_v.len} + {2'b00, col_v.len};
  end

endmodule

/* sv/token_position_record_encoder_unit.sv */
// ----------------------------------------------------------------------------
// token_position_record_encoder_unit
// Serializes token records into a byte stream with a last-byte marker.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Beat contents
//   in_rec    sink       token_code, file_index, line_number, column_number
//   out_rec   source     out_byte, last_byte (set on a record's final byte)
//
// A record is 5 to 11 bytes, sent one at a time on the single byte-wide
// output port. The next record waits in the input register and is packed and
// loaded into the shift buffer in the cycle its predecessor's last byte is
// taken, so bytes flow with no gap. An accepted record goes through the input
// register, then the shift buffer, to the port. Reset clears the valid flag
// and the byte count only. out_rec.ready low holds the current byte; the
// input register still takes one record ahead, then in_rec.ready stays low.
// ----------------------------------------------------------------------------
module token_position_record_encoder_unit (
  input logic       clk,
  input logic       rst_n,
  tpre_in_if.sink   in_rec,
  tpre_out_if.source out_rec
);

  tpre_pkg::record_t     rec_r;
  logic                  rec_vld_r;
  tpre_pkg::packed_rec_t pck;
  logic [tpre_pkg::BUF_W-1:0] buf_r;
  tpre_pkg::cnt_t        left_r;

  logic in_fire;
  logic out_fire;
  logic ser_free;
  logic load;

  tpre_pack u_pack (
    .rec (rec_r),
    .pck (pck)
  );

  assign out_fire = out_rec.valid && out_rec.ready;
  assign ser_free = (left_r == '0) || (out_fire && (left_r == 4'd1));
  assign load     = rec_vld_r && ser_free;
  assign in_rec.ready = !rec_vld_r || load;
  assign in_fire  = in_rec.valid && in_rec.ready;

  assign out_rec.valid     = (left_r != '0);
  assign out_rec.out_byte  = buf_r[tpre_pkg::BYTE_W-1:0];
  assign out_rec.last_byte = (left_r == 4'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_vld_r <= 1'b0;
    end else if (in_fire) begin
      rec_vld_r <= 1'b1;
    end else if (load) begin
      rec_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rec_r.token_code    <= in_rec.token_code;
      rec_r.file_index    <= in_rec.file_index;
      rec_r.line_number   <= in_rec.line_number;
      rec_r.column_number <= in_rec.column_number;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else if (load) begin
      left_r <= pck.count;
    end else if (out_fire) begin
      left_r <= left_r - 4'd1;
    end
  end

  // The byte on the port is always the low byte; each beat shifts the rest down.
  always_ff @(posedge clk) begin
    if (load) begin
      buf_r <= pck.bytes;
    end else if (out_fire) begin
      buf_r <= buf_r >> tpre_pkg::BYTE_W;
    end
  end

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Drives token records into the record encoder through a bursty sender and
// checks every serialized byte and last-byte flag against an in-bench encoder
// while the byte receiver stalls on rotating ready patterns.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int   RANDOM_RECORDS = 320;
  localparam int   QUIET_LIMIT    = 1000;
  localparam int   DRAIN_CYCLES   = 16;
  localparam int   REPORT_LIMIT   = 10;
  localparam tpre_pkg::pos_t ONE_BYTE_LIMIT = 22'd128;
  localparam tpre_pkg::pos_t TWO_BYTE_LIMIT = 22'd16384;
  localparam tpre_pkg::pos_t POS_MAX        = 22'h3FFFFF;

  typedef struct {
    tpre_pkg::byte_t value;
    logic            last;
  } enc_byte_t;

  logic clk = 1'b0;
  logic rst_n;

  tpre_in_if  in_ch ();
  tpre_out_if out_ch ();

  token_position_record_encoder_unit DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_rec  (in_ch),
    .out_rec (out_ch)
  );

  tpre_pkg::record_t pending_records[$];
  enc_byte_t awaited_bytes[$];
  int        total_records  = 0;
  int        records_taken  = 0;
  int        error_count    = 0;
  int        quiet_cycles   = 0;
  int        gap_left       = 0;
  int        burst_left     = 1;
  int        pattern_left   = 0;
  logic [15:0] ready_mask   = '1;
  logic      in_taken       = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void note_mismatch(string msg);
    error_count++;
    if (error_count <= REPORT_LIMIT) $display("MISMATCH: %s", msg);
  endfunction

  // Bytes of one record in wire order; the final byte carries the last flag.
  function automatic void encode_record(tpre_pkg::record_t r);
    tpre_pkg::byte_t seq[$];
    tpre_pkg::pos_t  vals[3];
    vals[0] = r.file_index;
    vals[1] = r.line_number;
    vals[2] = r.column_number;
    seq.push_back(r.token_code[7:0]);
    seq.push_back(r.token_code[15:8]);
    foreach (vals[i]) begin
      if (vals[i] < ONE_BYTE_LIMIT) begin
        seq.push_back(vals[i][7:0]);
      end else if (vals[i] < TWO_BYTE_LIMIT) begin
        seq.push_back({1'b1, vals[i][6:0]});
        seq.push_back({1'b0, vals[i][13:7]});
      end else begin
        seq.push_back({1'b1, vals[i][6:0]});
        seq.push_back({1'b1, vals[i][13:7]});
        seq.push_back(vals[i][21:14]);
      end
    end
    foreach (seq[i]) awaited_bytes.push_back('{seq[i], i == seq.size() - 1});
  endfunction

  // Spread positions over the one-, two- and three-byte forms.
  function automatic tpre_pkg::pos_t rand_position();
    case ($urandom_range(0, 4))
      0:       return tpre_pkg::pos_t'($urandom_range(0, 127));
      1:       return tpre_pkg::pos_t'($urandom_range(128, 16383));
      2:       return tpre_pkg::pos_t'($urandom_range(16384, 32'h3FFFFF));
      3:       return ($urandom_range(0, 1) == 0)
                        ? tpre_pkg::pos_t'(127 + $urandom_range(0, 2))
                        : tpre_pkg::pos_t'(16383 + $urandom_range(0, 2));
      default: return tpre_pkg::pos_t'($urandom);
    endcase
  endfunction

  // Sender: bursts of back-to-back records separated by random gaps.
  always @(negedge clk) begin
    logic              send;
    tpre_pkg::record_t rec;
    send = 1'b0;
    rec  = '0;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_records.size() > 0) begin
        send = 1'b1;
        rec  = pending_records.pop_front();
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      if (!send) rec = tpre_pkg::record_t'({$urandom, $urandom, $urandom});
      in_ch.valid         <= send;
      in_ch.token_code    <= rec.token_code;
      in_ch.file_index    <= rec.file_index;
      in_ch.line_number   <= rec.line_number;
      in_ch.column_number <= rec.column_number;
    end
  end

  // Receiver: ready follows a rotating mask that is reloaded now and then.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        pattern_left = $urandom_range(20, 80);
        case ($urandom_range(0, 3))
          0:       ready_mask = '1;
          1:       ready_mask = 16'h0101;
          default: ready_mask = 16'($urandom) | 16'h0001;
        endcase
      end
      pattern_left--;
      out_ch.ready <= ready_mask[0];
      ready_mask = {ready_mask[0], ready_mask[15:1]};
    end
  end

  // Monitor: predicts on each accepted record, checks each accepted byte.
  always @(posedge clk) begin
    enc_byte_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_ch.valid && in_ch.ready;
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_bytes.size() == 0) begin
          note_mismatch($sformatf("unexpected beat byte=%02h last=%b",
                                  out_ch.out_byte, out_ch.last_byte));
        end else begin
          want = awaited_bytes.pop_front();
          if (out_ch.out_byte !== want.value || out_ch.last_byte !== want.last)
            note_mismatch($sformatf("byte exp %02h got %02h, last exp %b got %b",
                                    want.value, out_ch.out_byte, want.last,
                                    out_ch.last_byte));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        encode_record('{in_ch.token_code, in_ch.file_index, in_ch.line_number,
                        in_ch.column_number});
        records_taken++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.token_code    = '0;
    in_ch.file_index    = '0;
    in_ch.line_number   = '0;
    in_ch.column_number = '0;
    out_ch.ready        = 1'b0;

    // Field extremes and every boundary of the compact position form.
    pending_records.push_back(tpre_pkg::record_t'{16'h0000, 22'd0, 22'd0, 22'd0});
    pending_records.push_back(tpre_pkg::record_t'{16'hFFFF, POS_MAX, POS_MAX, POS_MAX});
    pending_records.push_back(tpre_pkg::record_t'{16'h00FF, 22'd127, 22'd127, 22'd127});
    pending_records.push_back(tpre_pkg::record_t'{16'hFF00, 22'd128, 22'd128, 22'd128});
    pending_records.push_back(
      tpre_pkg::record_t'{16'h1234, 22'd16383, 22'd16383, 22'd16383});
    pending_records.push_back(
      tpre_pkg::record_t'{16'h8001, 22'd16384, 22'd16384, 22'd16384});
    pending_records.push_back(tpre_pkg::record_t'{16'h0001, 22'd127, 22'd128, 22'd16384});
    pending_records.push_back(tpre_pkg::record_t'{16'h7FFE, 22'd16383, POS_MAX, 22'd0});
    pending_records.push_back(
      tpre_pkg::record_t'{16'hAAAA, 22'h2AAAAA, 22'h155555, 22'h3FC07F});
    pending_records.push_back(
      tpre_pkg::record_t'{16'h5555, 22'h155555, 22'h2AAAAA, 22'd1});
    pending_records.push_back(tpre_pkg::record_t'{16'h0080, 22'd255, 22'd129, 22'd16385});
    pending_records.push_back(
      tpre_pkg::record_t'{16'h0100, 22'h3FFF80, 22'h003F80, 22'h200000});
    pending_records.push_back(tpre_pkg::record_t'{16'hC3C3, 22'd0, 22'd16384, 22'd127});
    pending_records.push_back(tpre_pkg::record_t'{16'h3C3C, POS_MAX, 22'd0, 22'd128});
    pending_records.push_back(
      tpre_pkg::record_t'{16'h8000, 22'h004000, 22'h007FFF, 22'h3FBFFF});
    pending_records.push_back(
      tpre_pkg::record_t'{16'h7FFF, 22'd1, 22'h3FFFFE, 22'd16383});
    for (int i = 0; i < RANDOM_RECORDS; i++)
      pending_records.push_back(tpre_pkg::record_t'{tpre_pkg::code_t'($urandom),
                                                    rand_position(), rand_position(),
                                                    rand_position()});
    total_records = pending_records.size();

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (records_taken != total_records || awaited_bytes.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (awaited_bytes.size() != 0)
      note_mismatch($sformatf("%0d bytes never arrived", awaited_bytes.size()));
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/tpre_pkg.sv
sv/tpre_in_if.sv
sv/tpre_out_if.sv
sv/tpre_pack.sv
sv/token_position_record_encoder_unit.sv
dv/tb_top.sv
